// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int DefOperandWidth = 32;
   localparam int FieldWidth = 32;
   localparam int ProdWidth = 2 * FieldWidth + 1;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
      OP_CMP = 3'd4, OP_NEG = 3'd5, OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2, ST_OVERFLOW = 2'd3
   } status_type;

   // classified transaction handed from front to back
   typedef struct packed {
      op_type                 op;
      status_type             early_st;
      logic                   an_neg;
      logic [FieldWidth-1:0]  an;
      logic [FieldWidth-1:0]  ad;
      logic                   bn_neg;
      logic [FieldWidth-1:0]  bn;
      logic [FieldWidth-1:0]  bd;
   } task_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_MUL1, BK_MUL2, BK_SUM, BK_GCD_DIV, BK_GCD_SWAP,
      BK_QN, BK_QD, BK_CHECK, BK_OUT
   } bk_state_type;
endpackage

// ===== design/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction add/sub/mul/div/compare/negate with gcd reduction.
// Errors are answered on acceptance; negate, compare and a zero numerator
// skip the gcd; others reduce by Euclid steps, all on one shared
// bit-serial divider. One transaction in the back end at a time; the
// next one starts the cycle after the held result is popped.
// Synchronous active-high reset empties the queue and the result register.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::DefOperandWidth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [2:0]   req_type,
   input  logic [31:0]  req_a_num,
   input  logic [31:0]  req_a_den,
   input  logic [31:0]  req_b_num,
   input  logic [31:0]  req_b_den,
   output logic         empty,
   input  logic         pop,
   output logic [31:0]  rsp_res_num,
   output logic [30:0]  rsp_res_den,
   output logic [1:0]   rsp_cmp_sign,
   output logic [1:0]   rsp_status
);
   import rau_pkg::*;
   logic     q_valid, q_pop;
   task_type q_task;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock, .reset, .push, .full, .req_type, .req_a_num, .req_a_den,
      .req_b_num, .req_b_den, .q_valid, .q_pop, .q_task
   );

   rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_task, .empty, .pop,
      .rsp_res_num, .rsp_res_den, .rsp_cmp_sign, .rsp_status
   );
endmodule

// ===== design/rau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front
// Accepts transactions, sign-normalizes operands and flags early errors.
// ----------------------------------------------------------------------------
module rau_front #(
   parameter int OPERAND_WIDTH = rau_pkg::DefOperandWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [2:0]                    req_type,
   input  logic [31:0]                   req_a_num,
   input  logic [31:0]                   req_a_den,
   input  logic [31:0]                   req_b_num,
   input  logic [31:0]                   req_b_den,
   output logic                          q_valid,
   input  logic                          q_pop,
   output rau_pkg::task_type             q_task
);
   import rau_pkg::*;
   localparam int W = OPERAND_WIDTH;
   localparam int Depth = 2;

   task_type          mem_ff [Depth];
   logic              wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   task_type          t_in;
   logic              do_push, do_pop;

   function automatic logic [FieldWidth:0] smag(input logic [31:0] raw);
      logic [W-1:0] x;
      logic [W-1:0] m;
      x = raw[W-1:0];
      m = x[W-1] ? (~x + 1'b1) : x;
      smag = {x[W-1], {(FieldWidth - W){1'b0}}, m};
      if (x[W-1] && m == '0) smag = {1'b1, {(FieldWidth - W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   endfunction

   always_comb begin
      logic [FieldWidth:0] an, ad, bn, bd;
      op_type op;
      an = smag(req_a_num);
      ad = smag(req_a_den);
      bn = smag(req_b_num);
      bd = smag(req_b_den);
      op = op_type'(req_type);
      t_in.op = op;
      t_in.an = an[FieldWidth-1:0];
      t_in.ad = ad[FieldWidth-1:0];
      t_in.bn = bn[FieldWidth-1:0];
      t_in.bd = bd[FieldWidth-1:0];
      t_in.an_neg = (an[FieldWidth] ^ ad[FieldWidth]) && an[FieldWidth-1:0] != '0;
      t_in.bn_neg = (bn[FieldWidth] ^ bd[FieldWidth]) && bn[FieldWidth-1:0] != '0;
      t_in.early_st = ST_OK;
      if (op == OP_RSV6 || op == OP_RSV7) t_in.early_st = ST_OK;
      else if (ad[FieldWidth-1:0] == '0 || (op != OP_NEG && bd[FieldWidth-1:0] == '0))
         t_in.early_st = ST_ZERO_DEN;
      else if (op == OP_DIV && bn[FieldWidth-1:0] == '0) t_in.early_st = ST_DIV_ZERO;
   end

   assign full = (cnt_ff == 2'(Depth));
   assign do_push = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign do_pop = q_pop && q_valid;
   assign q_task = mem_ff[rp_ff];
   assign wp_in = do_push ? ~wp_ff : wp_ff;
   assign rp_in = do_pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= t_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(Depth)) else $error("queue count over depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |=> cnt_ff != 2'd0) else $error("full queue lost entries");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("pop count mismatch");
endmodule

// ===== design/rau_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back
// Cross-multiplies, reduces by an iterative gcd and holds one result.
// ----------------------------------------------------------------------------
module rau_back #(
   parameter int OPERAND_WIDTH = rau_pkg::DefOperandWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  rau_pkg::task_type     q_task,
   output logic                  empty,
   input  logic                  pop,
   output logic [31:0]           rsp_res_num,
   output logic [30:0]           rsp_res_den,
   output logic [1:0]            rsp_cmp_sign,
   output logic [1:0]            rsp_status
);
   import rau_pkg::*;
   localparam int W = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int CW = $clog2(PW + 1);
   localparam logic [PW-1:0] Half = PW'(1) << (W - 1);

   bk_state_type          st_ff, st_in;
   task_type              t_ff, t_in;
   logic [PW-1:0]         p1_ff, p1_in, p2_ff, p2_in;
   logic                  p1n_ff, p1n_in;
   logic [PW:0]           num_ff, num_in;
   logic                  nneg_ff, nneg_in;
   logic [PW-1:0]         den_ff, den_in;
   logic [PW:0]           ga_ff, ga_in, gb_ff, gb_in;
   // shared restoring divider
   logic [PW:0]           dv_q_ff, dv_q_in, dv_r_ff, dv_r_in, dv_d_ff, dv_d_in;
   logic [CW-1:0]         dv_c_ff, dv_c_in;
   logic [PW:0]           rnum_ff, rnum_in;
   logic                  full_ff, full_in;
   logic [31:0]           o_num_ff, o_num_in;
   logic [30:0]           o_den_ff, o_den_in;
   logic [1:0]            o_cmp_ff, o_cmp_in, o_st_ff, o_st_in;
   logic [PW+1:0]         dv_trial;
   logic [PW:0]           dv_rs;
   logic                  dv_done;

   assign empty = !full_ff;
   assign rsp_res_num = o_num_ff;
   assign rsp_res_den = o_den_ff;
   assign rsp_cmp_sign = o_cmp_ff;
   assign rsp_status = o_st_ff;

   assign dv_rs = {dv_r_ff[PW-1:0], dv_q_ff[PW]};
   assign dv_trial = {1'b0, dv_rs} - {1'b0, dv_d_ff};
   assign dv_done = (dv_c_ff == CW'(0));

   always_comb begin
      logic [PW:0] s;
      logic [PW-1:0] fnum;
      logic ovf;
      st_in = st_ff; t_in = t_ff; p1_in = p1_ff; p2_in = p2_ff; p1n_in = p1n_ff;
      num_in = num_ff; nneg_in = nneg_ff; den_in = den_ff; ga_in = ga_ff; gb_in = gb_ff;
      dv_q_in = dv_q_ff; dv_r_in = dv_r_ff; dv_d_in = dv_d_ff; dv_c_in = dv_c_ff;
      rnum_in = rnum_ff;
      full_in = full_ff; o_num_in = o_num_ff; o_den_in = o_den_ff;
      o_cmp_in = o_cmp_ff; o_st_in = o_st_ff;
      q_pop = 1'b0;
      s = '0; fnum = '0; ovf = 1'b0;
      if (full_ff && pop) full_in = 1'b0;
      if (!dv_done) begin
         dv_c_in = dv_c_ff - CW'(1);
         if (!dv_trial[PW+1]) begin
            dv_r_in = dv_trial[PW:0];
            dv_q_in = {dv_q_ff[PW-1:0], 1'b1};
         end else begin
            dv_r_in = dv_rs;
            dv_q_in = {dv_q_ff[PW-1:0], 1'b0};
         end
      end
      case (st_ff)
         BK_IDLE: begin
            if (q_valid && !full_ff) begin
               q_pop = 1'b1;
               t_in = q_task;
               st_in = BK_MUL1;
               if (q_task.early_st != ST_OK || q_task.op == OP_RSV6 ||
                   q_task.op == OP_RSV7) begin
                  o_num_in = '0; o_den_in = 31'd1; o_cmp_in = 2'd0;
                  o_st_in = q_task.early_st;
                  full_in = 1'b1;
                  st_in = BK_IDLE;
               end else if (q_task.op == OP_NEG) begin
                  nneg_in = !q_task.an_neg && q_task.an[W-1:0] != '0;
                  num_in = (PW+1)'(q_task.an[W-1:0]);
                  den_in = PW'(q_task.ad[W-1:0]);
                  st_in = BK_CHECK;
               end
            end
         end
         BK_MUL1: begin
            case (t_ff.op)
               OP_MUL: begin
                  p1_in = t_ff.an[W-1:0] * t_ff.bn[W-1:0];
                  p1n_in = t_ff.an_neg ^ t_ff.bn_neg;
               end
               default: begin
                  p1_in = t_ff.an[W-1:0] * t_ff.bd[W-1:0];
                  p1n_in = t_ff.an_neg;
               end
            endcase
            st_in = BK_MUL2;
         end
         BK_MUL2: begin
            case (t_ff.op)
               OP_MUL: p2_in = t_ff.ad[W-1:0] * t_ff.bd[W-1:0];
               OP_DIV: begin
                  p2_in = t_ff.ad[W-1:0] * t_ff.bn[W-1:0];
                  p1n_in = p1n_ff ^ t_ff.bn_neg;
               end
               default: p2_in = t_ff.ad[W-1:0] * t_ff.bn[W-1:0];
            endcase
            st_in = BK_SUM;
         end
         BK_SUM: begin
            if (t_ff.op == OP_MUL || t_ff.op == OP_DIV) begin
               num_in = {1'b0, p1_ff};
               nneg_in = p1n_ff && p1_ff != '0;
               den_in = p2_ff;
               st_in = BK_MUL1;
               // for mul/div both products are ready; here den is p2
            end else begin
               // p2 holds ad*bn; term b sign
               logic tneg;
               tneg = t_ff.bn_neg ^ (t_ff.op != OP_ADD);
               if (p1n_ff == tneg) begin
                  s = {1'b0, p1_ff} + {1'b0, p2_ff};
                  nneg_in = p1n_ff;
               end else if (p1_ff >= p2_ff) begin
                  s = {1'b0, p1_ff - p2_ff};
                  nneg_in = p1n_ff;
               end else begin
                  s = {1'b0, p2_ff - p1_ff};
                  nneg_in = tneg;
               end
               if (s == '0) nneg_in = 1'b0;
               num_in = s;
               den_in = t_ff.ad[W-1:0] * t_ff.bd[W-1:0];
               st_in = BK_MUL1;
            end
            if (t_ff.op == OP_CMP) begin
               o_num_in = '0; o_den_in = 31'd1; o_st_in = ST_OK;
               o_cmp_in = (s == '0) ? 2'd0 : (nneg_in ? 2'b11 : 2'b01);
               full_in = 1'b1;
               st_in = BK_IDLE;
            end else begin
               ga_in = (t_ff.op == OP_MUL || t_ff.op == OP_DIV) ? {1'b0, p1_ff} : s;
               gb_in = (t_ff.op == OP_MUL || t_ff.op == OP_DIV) ? {1'b0, p2_ff}
                       : {1'b0, PW'(t_ff.ad[W-1:0] * t_ff.bd[W-1:0])};
               st_in = (ga_in == '0) ? BK_CHECK : BK_GCD_SWAP;
            end
         end
         BK_GCD_SWAP: begin
            if (gb_ff == '0) begin
               dv_q_in = num_ff; dv_r_in = '0; dv_d_in = ga_ff;
               dv_c_in = CW'(PW + 1);
               st_in = BK_QN;
            end else begin
               dv_q_in = ga_ff; dv_r_in = '0; dv_d_in = gb_ff;
               dv_c_in = CW'(PW + 1);
               st_in = BK_GCD_DIV;
            end
         end
         BK_GCD_DIV: begin
            if (dv_done) begin
               ga_in = gb_ff;
               gb_in = dv_r_ff;
               st_in = BK_GCD_SWAP;
            end
         end
         BK_QN: begin
            if (dv_done) begin
               rnum_in = dv_q_ff;
               dv_q_in = {1'b0, den_ff}; dv_r_in = '0; dv_d_in = ga_ff;
               dv_c_in = CW'(PW + 1);
               st_in = BK_QD;
            end
         end
         BK_QD: begin
            if (dv_done) begin
               num_in = rnum_ff;
               den_in = dv_q_ff[PW-1:0];
               st_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            ovf = (nneg_ff ? num_ff > {1'b0, Half} : num_ff > {1'b0, Half - 1'b1})
                  || den_ff > Half - 1'b1;
            fnum = nneg_ff ? (PW'(0) - num_ff[PW-1:0]) : num_ff[PW-1:0];
            o_cmp_in = 2'd0;
            if (ovf) begin
               o_num_in = '0; o_den_in = 31'd1; o_st_in = ST_OVERFLOW;
            end else begin
               o_num_in = 32'($signed(fnum[W-1:0]));
               o_den_in = 31'(den_ff);
               o_st_in = ST_OK;
            end
            full_in = 1'b1;
            st_in = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         full_ff <= 1'b0;
         dv_c_ff <= '0;
      end else begin
         st_ff <= st_in;
         full_ff <= full_in;
         dv_c_ff <= dv_c_in;
      end
      t_ff <= t_in; p1_ff <= p1_in; p2_ff <= p2_in; p1n_ff <= p1n_in;
      num_ff <= num_in; nneg_ff <= nneg_in; den_ff <= den_in;
      ga_ff <= ga_in; gb_ff <= gb_in; rnum_ff <= rnum_in;
      dv_q_ff <= dv_q_in; dv_r_ff <= dv_r_in; dv_d_ff <= dv_d_in;
      o_num_ff <= o_num_in; o_den_ff <= o_den_in; o_cmp_ff <= o_cmp_in; o_st_ff <= o_st_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (full_ff && !pop) |=> full_ff && $stable(o_num_ff) && $stable(o_st_ff))
      else $error("result changed while waiting");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (full_ff && o_st_ff != ST_OK) |-> o_num_ff == '0 && o_den_ff == 31'd1)
      else $error("error result not cleared");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == BK_IDLE && !full_ff) else $error("took task while busy");
endmodule

// ===== dv/rau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Watches both queue ports of the rational arithmetic unit, computes the
// expected fraction for every accepted request and compares each popped
// response against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module rau_checker #(
   parameter int W = rau_pkg::DefOperandWidth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         full,
   input  logic [2:0]   req_type,
   input  logic [31:0]  req_a_num,
   input  logic [31:0]  req_a_den,
   input  logic [31:0]  req_b_num,
   input  logic [31:0]  req_b_den,
   input  logic         empty,
   input  logic         pop,
   input  logic [31:0]  rsp_res_num,
   input  logic [30:0]  rsp_res_den,
   input  logic [1:0]   rsp_cmp_sign,
   input  logic [1:0]   rsp_status,
   output int           errors,
   output int           outstanding
);
   import rau_pkg::*;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0]  cmp;
      logic [1:0]  st;
   } fraction_type;

   fraction_type pending_results[$];

   function automatic void to_sm(input logic [31:0] raw, output bit neg,
                                 output logic [63:0] mag);
      logic [63:0] mask, top, x;
      mask = (W >= 64) ? '1 : ((64'd1 << W) - 64'd1);
      top  = 64'd1 << (W - 1);
      x    = {32'd0, raw} & mask;
      if ((x & top) != 0) begin
         neg = 1'b1;
         mag = (~x + 64'd1) & mask;
         if (mag == 0) mag = top;
      end else begin
         neg = 1'b0;
         mag = x;
      end
   endfunction

   function automatic void sm_mul(input bit an, input logic [63:0] am, input bit bn,
                                  input logic [63:0] bm, output bit rn,
                                  output logic [63:0] rm);
      rm = am * bm;
      rn = (rm != 0) && (an != bn);
   endfunction

   function automatic void sm_add(input bit an, input logic [63:0] am, input bit bn,
                                  input logic [63:0] bm, output bit rn,
                                  output logic [63:0] rm);
      if (an == bn) begin
         rn = an;
         rm = am + bm;
      end else if (am >= bm) begin
         rn = an;
         rm = am - bm;
      end else begin
         rn = bn;
         rm = bm - am;
      end
      if (rm == 0) rn = 1'b0;
   endfunction

   function automatic fraction_type make_result(bit neg, logic [63:0] mag,
                                                logic [63:0] den, logic [1:0] cmp,
                                                status_type st);
      fraction_type r;
      logic [63:0] n;
      n = neg ? (64'd0 - mag) : mag;
      r.num = n[31:0];
      r.den = den[30:0];
      r.cmp = cmp;
      r.st  = st;
      return r;
   endfunction

   function automatic fraction_type compute_fraction(logic [2:0] op_raw,
         logic [31:0] an_r, logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r);
      op_type      op;
      bit          an_s, ad_s, bn_s, bd_s, t_s, u_s, num_s, den_s;
      logic [63:0] an_m, ad_m, bn_m, bd_m, t_m, u_m, num_m, den_m, half, g, a, b, tmp;
      op   = op_type'(op_raw);
      half = 64'd1 << (W - 1);
      to_sm(an_r, an_s, an_m);
      to_sm(ad_r, ad_s, ad_m);
      to_sm(bn_r, bn_s, bn_m);
      to_sm(bd_r, bd_s, bd_m);
      if (op == OP_RSV6 || op == OP_RSV7) return make_result(0, 0, 1, 2'b00, ST_OK);
      if (ad_m == 0 || (op != OP_NEG && bd_m == 0))
         return make_result(0, 0, 1, 2'b00, ST_ZERO_DEN);
      if (ad_s) begin
         ad_s = 0;
         if (an_m != 0) an_s = !an_s;
      end
      if (bd_s) begin
         bd_s = 0;
         if (bn_m != 0) bn_s = !bn_s;
      end
      if (op == OP_NEG) begin
         num_s = (an_m != 0) ? !an_s : an_s;
         if ((num_s ? an_m > half : an_m > half - 1) || ad_m > half - 1)
            return make_result(0, 0, 1, 2'b00, ST_OVERFLOW);
         return make_result(num_s, an_m, ad_m, 2'b00, ST_OK);
      end
      case (op)
         OP_ADD, OP_SUB, OP_CMP: begin
            sm_mul(ad_s, ad_m, bn_s, bn_m, t_s, t_m);
            if (op != OP_ADD && t_m != 0) t_s = !t_s;
            sm_mul(an_s, an_m, bd_s, bd_m, u_s, u_m);
            sm_add(u_s, u_m, t_s, t_m, num_s, num_m);
            sm_mul(ad_s, ad_m, bd_s, bd_m, den_s, den_m);
         end
         OP_MUL: begin
            sm_mul(an_s, an_m, bn_s, bn_m, num_s, num_m);
            sm_mul(ad_s, ad_m, bd_s, bd_m, den_s, den_m);
         end
         default: begin
            if (bn_m == 0) return make_result(0, 0, 1, 2'b00, ST_DIV_ZERO);
            sm_mul(an_s, an_m, bd_s, bd_m, num_s, num_m);
            sm_mul(ad_s, ad_m, bn_s, bn_m, den_s, den_m);
         end
      endcase
      if (den_s) begin
         den_s = 0;
         if (num_m != 0) num_s = !num_s;
      end
      if (op == OP_CMP)
         return make_result(0, 0, 1, (num_m == 0) ? 2'b00 : (num_s ? 2'b11 : 2'b01), ST_OK);
      if (num_m != 0) begin
         a = num_m;
         b = den_m;
         while (b != 0) begin
            tmp = a % b;
            a = b;
            b = tmp;
         end
         g = a;
         num_m = num_m / g;
         den_m = den_m / g;
      end
      if ((num_s ? num_m > half : num_m > half - 1) || den_m > half - 1)
         return make_result(0, 0, 1, 2'b00, ST_OVERFLOW);
      return make_result(num_s, num_m, den_m, 2'b00, ST_OK);
   endfunction

   always @(posedge clock) begin
      fraction_type exp_r, got;
      if (reset) begin
         pending_results.delete();
         errors <= 0;
         outstanding <= 0;
      end else begin
         if (push && !full)
            pending_results.push_back(compute_fraction(req_type, req_a_num, req_a_den,
                                                       req_b_num, req_b_den));
         if (pop && !empty) begin
            got = {rsp_res_num, rsp_res_den, rsp_cmp_sign, rsp_status};
            if (pending_results.size() == 0) begin
               if (errors < 10) $display("ERROR: unexpected transaction %h", got);
               errors <= errors + 1;
            end else begin
               exp_r = pending_results.pop_front();
               if (got !== exp_r) begin
                  if (errors < 10)
                     $display("ERROR: num %h/%h den %h/%h cmp %b/%b st %0d/%0d (exp/act)",
                              exp_r.num, got.num, exp_r.den, got.den, exp_r.cmp, got.cmp,
                              exp_r.st, got.st);
                  errors <= errors + 1;
               end
            end
         end
         outstanding <= pending_results.size();
      end
   end
endmodule

// ===== dv/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction transactions into the rational
// arithmetic unit under varying sender and receiver idling; the checker
// module predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   localparam longint Limit = 40_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        full, empty;
   logic        pop = 0;
   logic        hold_pop = 0;
   logic [2:0]  req_type = '0;
   logic [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic [1:0]  rsp_cmp_sign, rsp_status;
   int          errors, outstanding;
   int          send_idle_pct = 0, stall_pct = 0;
   longint      cycles = 0;

   rational_arithmetic_unit dut (.*);
   rau_checker chk (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > Limit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_pop) begin
         pop <= 0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send(op_type op, logic [31:0] an, logic [31:0] ad,
                       logic [31:0] bn, logic [31:0] bd);
      int gap;
      req_type  <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      push      <= 1;
      @(posedge clock);
      while (full) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rnd_val();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(4)) - 2);
         3, 4: return $urandom;
         5, 6: return 32'(signed'($urandom_range(64)) - 32);
         default: return 32'(signed'($urandom_range(65535)) - 32768);
      endcase
   endfunction

   function automatic logic [31:0] rnd_den();
      if ($urandom_range(99) < 3) return 0;
      return rnd_val();
   endfunction

   task automatic idle_until_drained();
      push <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8000) @(posedge clock);
   endtask

   task automatic random_phase(int n, int idle, int stall);
      op_type op;
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (n) begin
         op = op_type'(($urandom_range(99) < 4) ? $urandom_range(6, 7) : $urandom_range(5));
         send(op, rnd_val(), rnd_den(), rnd_val(), rnd_den());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(OP_ADD, 1, 2, 1, 3);
      send(OP_SUB, 1, 2, 1, 2);
      send(OP_MUL, 32'hffff_fffe, 4, 3, 32'hffff_fffa);
      send(OP_DIV, 3, 4, 0, 5);
      send(OP_DIV, 32'h7fff_ffff, 1, 32'h8000_0000, 1);
      send(OP_CMP, 1, 3, 1, 2);
      send(OP_CMP, 2, 4, 1, 2);
      send(OP_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
      send(OP_NEG, 32'h8000_0000, 1, 0, 0);
      send(OP_NEG, 32'h7fff_ffff, 32'h8000_0001, 0, 0);
      send(OP_NEG, 5, 32'h8000_0000, 0, 0);
      send(OP_ADD, 1, 0, 1, 1);
      send(OP_MUL, 1, 1, 1, 0);
      send(OP_ADD, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff);
      send(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      send(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_SUB, 32'h8000_0000, 1, 1, 1);
      send(OP_RSV6, 1, 1, 1, 1);
      send(OP_RSV7, 32'hffff_ffff, 0, 32'hffff_ffff, 0);
      send(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      idle_until_drained();
      // random phases
      random_phase(250, 0, 0);
      random_phase(250, 45, 0);
      random_phase(250, 0, 45);
      fork
         begin
            hold_pop <= 1;
            repeat (20000) @(posedge clock);
            hold_pop <= 0;
         end
         random_phase(200, 0, 0);
      join
      idle_until_drained();
      random_phase(250, 13, 13);
      idle_until_drained();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
